FILE: design/jhtd_pkg.sv
// ----------------------------------------------------------------------------
// jhtd_pkg
// Shared types and constants for the Huffman table loader and decoder.
// ----------------------------------------------------------------------------
package jhtd_pkg;

    localparam int LENGTHS = 16;
    localparam int CODE_W  = 17;
    localparam logic [CODE_W-1:0] CODE_SAT = '1;

    // input opcodes
    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_BYTE   = 2'd1;
    localparam logic [1:0] OP_DECODE = 2'd2;

    typedef enum logic [1:0] {
        K_BEGIN  = 2'd0,
        K_BYTE   = 2'd1,
        K_DECODE = 2'd2,
        K_NOP    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_TAKEN    = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_DECODED  = 3'd2,
        ST_NOMATCH  = 3'd3,
        ST_BADHDR   = 3'd4,
        ST_TOOMANY  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_COUNTS  = 2'd1,
        PH_SYMBOLS = 2'd2
    } phase_t;

    // one classified item in the queue
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [15:0] bit_window;
        logic [2:0]  table_select;
    } item_t;

    // queue to executor handshake
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_out_t;

endpackage

FILE: design/jhtd_front.sv
// ----------------------------------------------------------------------------
// jhtd_front
// Accepts input transactions, classifies the opcode and queues the item.
// ----------------------------------------------------------------------------
module jhtd_front
    import jhtd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  data_byte,
    input  logic [15:0] bit_window,
    input  logic [2:0]  table_select,
    output q_out_t      q_out,
    input  logic        q_pop
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t      new_item;
    logic       push;

    // classify the opcode
    always_comb begin
        case (opcode)
            OP_BEGIN:  new_item.kind = K_BEGIN;
            OP_BYTE:   new_item.kind = K_BYTE;
            OP_DECODE: new_item.kind = K_DECODE;
            default:   new_item.kind = K_NOP;
        endcase
        new_item.data_byte    = data_byte;
        new_item.bit_window   = bit_window;
        new_item.table_select = table_select;
    end

    assign in_ready    = (count_reg != 2'd2);
    assign push        = in_valid && in_ready;
    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

FILE: design/jhtd_back.sv
// ----------------------------------------------------------------------------
// jhtd_back
// Executes queued items: builds canonical tables and decodes scan windows.
// ----------------------------------------------------------------------------
module jhtd_back
    import jhtd_pkg::*;
#(
    parameter int NUM_TABLES    = 8,
    parameter int MAX_SYMBOLS   = 256,
    parameter int MAX_CODE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  q_out_t      q_in,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [7:0]  symbol,
    output logic [4:0]  code_length,
    output logic [2:0]  table_index
);

    localparam int TW  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int SW  = $clog2(MAX_SYMBOLS);
    localparam int SLW = SW + 1;
    localparam int AW  = TW + SW;

    typedef enum logic [1:0] {
        S_RUN  = 2'b01,
        S_LOOK = 2'b10
    } state_t;

    // table rows
    logic [7:0]        cnt_reg   [NUM_TABLES][LENGTHS];
    logic [CODE_W-1:0] fcode_reg [NUM_TABLES][LENGTHS];
    logic [SLW-1:0]    fsym_reg  [NUM_TABLES][LENGTHS];
    logic [7:0]        sym_mem   [2**AW];
    logic [7:0]        rd_data_reg;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [2:0]        load_reg, load_next;
    logic [3:0]        pos_reg, pos_next;
    logic [11:0]       left_reg, left_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [SLW-1:0]    wslot_reg, wslot_next;
    logic              bad_reg, bad_next;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        status_reg, status_next;
    logic [7:0]        symbol_reg;
    logic [4:0]        len_reg, len_next;
    logic [2:0]        tab_reg, tab_next;
    logic              found_reg, found_next;

    item_t             it;
    logic              out_free;
    logic              take_sym;

    // table write controls
    logic              cnt_we, row_clr, sym_we, rd_en;
    logic [TW-1:0]     row_idx;
    logic [7:0]        kept;
    logic [SLW-1:0]    base;
    logic [AW-1:0]     rd_addr;

    // count phase arithmetic
    logic [SLW-1:0]    room;
    logic [CODE_W+1:0] code_sum;
    logic [11:0]       left_sum;
    logic [3:0]        hdr_cls, hdr_id;
    logic [5:0]        hdr_idx;
    logic              hdr_bad;

    // lookup
    logic [TW-1:0]     sel_idx;
    logic              sel_ok;
    logic [LENGTHS-1:0] hit;
    logic [7:0]        diff [LENGTHS];
    logic              any_hit;
    logic [4:0]        hit_len;
    logic [7:0]        hit_diff;
    logic [SLW-1:0]    hit_fsym;
    logic [SLW:0]      slot_sum;
    logic [SW-1:0]     slot;

    assign it       = q_in.item;
    assign out_free = !out_valid_reg || out_ready;
    assign row_idx  = load_reg[TW-1:0];
    assign sel_idx  = it.table_select[TW-1:0];
    assign sel_ok   = ({1'b0, it.table_select} < 4'(NUM_TABLES));

    // parallel compare over all code lengths of the selected table
    always_comb begin
        logic [16:0] code_l;
        logic [16:0] d;
        for (int l = 0; l < LENGTHS; l++) begin
            code_l  = {1'b0, 16'(it.bit_window >> (LENGTHS - 1 - l))};
            d       = code_l - fcode_reg[sel_idx][l];
            diff[l] = d[7:0];
            hit[l]  = sel_ok && (l < MAX_CODE_BITS) && (cnt_reg[sel_idx][l] != 8'd0)
                      && (code_l >= fcode_reg[sel_idx][l])
                      && (d < {9'd0, cnt_reg[sel_idx][l]});
        end
    end

    // shortest matching length wins
    always_comb begin
        any_hit  = 1'b0;
        hit_len  = 5'd0;
        hit_diff = 8'd0;
        hit_fsym = '0;
        for (int l = LENGTHS - 1; l >= 0; l--) begin
            if (hit[l]) begin
                any_hit  = 1'b1;
                hit_len  = 5'(l + 1);
                hit_diff = diff[l];
                hit_fsym = fsym_reg[sel_idx][l];
            end
        end
        slot_sum = {1'b0, hit_fsym} + (SLW + 1)'(hit_diff);
        if (slot_sum >= (SLW + 1)'(MAX_SYMBOLS)) begin
            slot = SW'(MAX_SYMBOLS - 1);
        end else begin
            slot = slot_sum[SW-1:0];
        end
        rd_addr = {sel_idx, slot};
    end

    // count phase arithmetic
    always_comb begin
        base     = (left_reg < 12'(MAX_SYMBOLS)) ? left_reg[SLW-1:0] : SLW'(MAX_SYMBOLS);
        room     = SLW'(MAX_SYMBOLS) - base;
        kept     = ({1'b0, it.data_byte} < 9'(room)) ? it.data_byte : 8'(room);
        code_sum = ({2'b00, code_reg} + (CODE_W + 2)'(it.data_byte)) << 1;
        left_sum = left_reg + 12'(it.data_byte);
        hdr_cls  = it.data_byte[7:4];
        hdr_id   = it.data_byte[3:0];
        hdr_idx  = {hdr_cls, 2'b00} + {2'b00, hdr_id};
        hdr_bad  = (hdr_cls > 4'd1) || (hdr_id > 4'd3) || (hdr_idx >= 6'(NUM_TABLES));
    end

    // executor control
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        load_next      = load_reg;
        pos_next       = pos_reg;
        left_next      = left_reg;
        code_next      = code_reg;
        wslot_next     = wslot_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        len_next       = len_reg;
        tab_next       = tab_reg;
        found_next     = found_reg;
        take_sym       = 1'b0;
        q_pop          = 1'b0;
        cnt_we         = 1'b0;
        row_clr        = 1'b0;
        sym_we         = 1'b0;
        rd_en          = 1'b0;

        case (state_reg)
            S_RUN: begin
                if (q_in.valid && out_free) begin
                    q_pop          = 1'b1;
                    len_next       = 5'd0;
                    status_next    = ST_TAKEN;
                    tab_next       = load_reg;
                    out_valid_next = 1'b1;
                    case (it.kind)
                        K_BEGIN: begin
                            phase_next = PH_HEADER;
                            pos_next   = 4'd0;
                            left_next  = 12'd0;
                            code_next  = '0;
                            wslot_next = '0;
                            bad_next   = 1'b0;
                        end
                        K_DECODE: begin
                            out_valid_next = 1'b0;
                            found_next     = any_hit;
                            len_next       = hit_len;
                            tab_next       = it.table_select;
                            rd_en          = any_hit;
                            state_next     = S_LOOK;
                        end
                        K_BYTE: begin
                            case (phase_reg)
                                PH_COUNTS: begin
                                    cnt_we    = !bad_reg;
                                    code_next = (code_sum > (CODE_W + 2)'(CODE_SAT))
                                                ? CODE_SAT : code_sum[CODE_W-1:0];
                                    left_next = left_sum;
                                    tab_next  = bad_reg ? 3'd0 : load_reg;
                                    if (pos_reg == 4'(LENGTHS - 1)) begin
                                        pos_next   = 4'd0;
                                        wslot_next = '0;
                                        if (left_sum == 12'd0) begin
                                            phase_next  = PH_HEADER;
                                            status_next = bad_reg ? ST_BADHDR : ST_COMPLETE;
                                        end else begin
                                            phase_next = PH_SYMBOLS;
                                            if (!bad_reg && left_sum > 12'(MAX_SYMBOLS)) begin
                                                status_next = ST_TOOMANY;
                                            end
                                        end
                                    end else begin
                                        pos_next = pos_reg + 4'd1;
                                    end
                                end
                                PH_SYMBOLS: begin
                                    tab_next = bad_reg ? 3'd0 : load_reg;
                                    if (wslot_reg < SLW'(MAX_SYMBOLS)) begin
                                        sym_we     = !bad_reg;
                                        wslot_next = wslot_reg + SLW'(1);
                                    end
                                    if (left_reg != 12'd0) begin
                                        left_next = left_reg - 12'd1;
                                    end
                                    if (left_reg <= 12'd1) begin
                                        phase_next  = PH_HEADER;
                                        status_next = bad_reg ? ST_BADHDR : ST_COMPLETE;
                                    end
                                end
                                default: begin
                                    // header byte
                                    phase_next = PH_COUNTS;
                                    pos_next   = 4'd0;
                                    left_next  = 12'd0;
                                    code_next  = '0;
                                    wslot_next = '0;
                                    if (hdr_bad) begin
                                        bad_next    = 1'b1;
                                        status_next = ST_BADHDR;
                                        tab_next    = 3'd0;
                                    end else begin
                                        bad_next  = 1'b0;
                                        load_next = hdr_idx[2:0];
                                        tab_next  = hdr_idx[2:0];
                                        row_clr   = 1'b1;
                                    end
                                end
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            S_LOOK: begin
                if (out_free) begin
                    take_sym       = 1'b1;
                    out_valid_next = 1'b1;
                    status_next    = found_reg ? ST_DECODED : ST_NOMATCH;
                    state_next     = S_RUN;
                end
            end
            default: state_next = S_RUN;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_RUN;
            phase_reg     <= PH_HEADER;
            load_reg      <= 3'd0;
            pos_reg       <= 4'd0;
            left_reg      <= 12'd0;
            code_reg      <= '0;
            wslot_reg     <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            load_reg      <= load_next;
            pos_reg       <= pos_next;
            left_reg      <= left_next;
            code_reg      <= code_next;
            wslot_reg     <= wslot_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        len_reg    <= len_next;
        tab_reg    <= tab_next;
        found_reg  <= found_next;
        if (q_pop) begin
            symbol_reg <= 8'd0;
        end else if (take_sym) begin
            symbol_reg <= found_reg ? rd_data_reg : 8'd0;
        end
    end

    // per-length table rows
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < NUM_TABLES; t++) begin
                for (int l = 0; l < LENGTHS; l++) begin
                    cnt_reg[t][l]   <= 8'd0;
                    fcode_reg[t][l] <= '0;
                    fsym_reg[t][l]  <= '0;
                end
            end
        end else if (row_clr) begin
            for (int l = 0; l < LENGTHS; l++) begin
                cnt_reg[hdr_idx[TW-1:0]][l] <= 8'd0;
            end
        end else if (cnt_we) begin
            cnt_reg[row_idx][pos_reg]   <= kept;
            fcode_reg[row_idx][pos_reg] <= code_reg;
            fsym_reg[row_idx][pos_reg]  <= base;
        end
    end

    // symbol memory write
    always_ff @(posedge aclk) begin
        if (sym_we) begin
            sym_mem[{row_idx, wslot_reg[SW-1:0]}] <= it.data_byte;
        end
    end

    // symbol memory read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= sym_mem[rd_addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign symbol      = symbol_reg;
    assign code_length = len_reg;
    assign table_index = tab_reg;

endmodule

FILE: design/jpeg_huffman_table_decoder_core.sv
// A table byte's result is registered when the executor pops it from the queue.
// Throughput: one table byte per cycle while each result is taken; a decode holds the
// executor in S_LOOK after the length compare for the registered symbol memory read.
// A 2-entry queue lets input keep flowing while a result waits on m_axis_tready.
// Reset (aresetn, synchronous, active low) empties all tables and the parser;
// symbol memory is not cleared and is valid only once written.
// ----------------------------------------------------------------------------
// jpeg_huffman_table_decoder_core
// Loads canonical Huffman tables from table segment bytes and decodes codes.
// ----------------------------------------------------------------------------
module jpeg_huffman_table_decoder_core
    import jhtd_pkg::*;
#(
    parameter int NUM_TABLES    = 8,
    parameter int MAX_SYMBOLS   = 256,
    parameter int MAX_CODE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // data_byte[7:0], bit_window[23:8]
    input  logic [4:0]  s_axis_tuser,  // opcode[1:0], table_select[4:2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // symbol[7:0], code_length[12:8], zero[15:13]
    output logic [5:0]  m_axis_tuser   // status[2:0], table_index[5:3]
);

    q_out_t     q;
    logic       q_pop;
    logic [2:0] status;
    logic [7:0] symbol;
    logic [4:0] code_length;
    logic [2:0] table_index;

    jhtd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .opcode       (s_axis_tuser[1:0]),
        .data_byte    (s_axis_tdata[7:0]),
        .bit_window   (s_axis_tdata[23:8]),
        .table_select (s_axis_tuser[4:2]),
        .q_out        (q),
        .q_pop        (q_pop)
    );

    jhtd_back #(
        .NUM_TABLES    (NUM_TABLES),
        .MAX_SYMBOLS   (MAX_SYMBOLS),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_in        (q),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .status      (status),
        .symbol      (symbol),
        .code_length (code_length),
        .table_index (table_index)
    );

    assign m_axis_tdata = {3'b000, code_length, symbol};
    assign m_axis_tuser = {table_index, status};

endmodule
